FILE: rtl/core/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg: shared types and constants of the distance-vector route table
// Table size, field widths, item and route entry structs, opcodes and
// sequencer states used by the front, back and top level.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  // table geometry: labels are 4 bits, so at most 16 entries
  localparam int NODES = 16;
  localparam int TBL   = (NODES < 16) ? NODES : 16;
  localparam int IDX_W = (TBL > 1) ? $clog2(TBL) : 1;

  // field widths
  localparam int LBL_W      = 4;
  localparam int COST_W     = 8;
  localparam int TTL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // reciprocal of three: floor(x * 43691 / 2^17) == floor(x / 3) for 16-bit x
  localparam logic [16:0] DIV3_RECIP = 17'd43691;
  localparam int          DIV3_SHIFT = 17;

  // item opcodes
  typedef enum logic [1:0] {
    OP_RECV = 2'd0,
    OP_ADV  = 2'd1,
    OP_AGE  = 2'd2,
    OP_LOAD = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INF   = 2'd0,
    CFG_TTL   = 2'd1,
    CFG_SPLIT = 2'd2
  } cfg_reg_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECV,
    ST_AGE,
    ST_ADV
  } state_t;

  // one queued command
  typedef struct packed {
    op_t               func;
    logic [LBL_W-1:0]  peer;
    logic [LBL_W-1:0]  dest;
    logic [COST_W-1:0] adv_cost;
    logic [TTL_W-1:0]  adv_ttl;
    logic              is_neighbor;
  } cmd_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [COST_W-1:0] infinity_cost;
    logic [TTL_W-1:0]  ttl_default;
    logic              split_horizon_on;
    logic [TTL_W-1:0]  age_step;
  } cfg_t;

  // one route table entry
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [LBL_W-1:0]  next_hop;
    logic              hop_valid;
    logic [TTL_W-1:0]  ttl;
  } route_t;

endpackage

FILE: rtl/core/dvrt_front.sv
// ----------------------------------------------------------------------------
// dvrt_front: input acceptance and command queue
// Takes input beats, drops receive and load items whose labels fall outside
// the table, and queues the rest for the back end in a two-entry fifo.
// ----------------------------------------------------------------------------
module dvrt_front
  import dvrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [LBL_W-1:0]  in_peer,
  input  logic [LBL_W-1:0]  in_dest,
  input  logic [COST_W-1:0] in_adv_cost,
  input  logic [TTL_W-1:0]  in_adv_ttl,
  input  logic              in_is_neighbor,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  cmd_t              cmd_in;
  logic              keep;
  logic              push;
  logic              pop;

  // label lies inside the table
  function automatic logic in_table(input logic [LBL_W-1:0] lbl);
    in_table = ({1'b0, lbl} < (LBL_W + 1)'(TBL));
  endfunction

  // classify the incoming beat
  always_comb begin
    cmd_in.func        = op_t'(in_func);
    cmd_in.peer        = in_peer;
    cmd_in.dest        = in_dest;
    cmd_in.adv_cost    = in_adv_cost;
    cmd_in.adv_ttl     = in_adv_ttl;
    cmd_in.is_neighbor = in_is_neighbor;
    unique case (cmd_in.func)
      OP_LOAD: keep = in_table(in_dest);
      OP_RECV: keep = in_table(in_dest) && in_table(in_peer);
      default: keep = 1'b1;
    endcase
  end

  // queue handshakes
  assign in_ready  = (count_r != QCNT_W'(QDEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_mem[rd_ptr_r];
  assign push      = in_valid && in_ready && keep;
  assign pop       = cmd_valid && cmd_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

FILE: rtl/core/dvrt_back.sv
// ----------------------------------------------------------------------------
// dvrt_back: route table and command sequencer
// Holds the route table memory and carries out queued commands: loads,
// Bellman-Ford relaxation of received entries, aging of neighbor TTLs and
// table walks that expire stale entries and stream advertisement beats.
// ----------------------------------------------------------------------------
module dvrt_back
  import dvrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LBL_W-1:0]  out_dest,
  output logic [LBL_W-1:0]  out_next_hop,
  output logic              out_hop_valid,
  output logic [COST_W-1:0] out_cost,
  output logic [TTL_W-1:0]  out_ttl,
  output logic              out_last
);

  // table memory, one write and two registered reads
  route_t            mem [TBL];
  route_t            rd_a_r;
  route_t            rd_b_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr_a;
  logic [IDX_W-1:0]  rd_addr_b;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  route_t            wr_data;

  // sequencer state
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  cmd_t              cur_r, cur_nxt;
  logic              idx_last;
  logic [IDX_W-1:0]  idx_inc;

  // computed entries
  route_t            load_entry;
  route_t            rx_entry;
  route_t            age_entry;
  route_t            exp_entry;
  logic [TTL_W-1:0]  recv_ttl;
  logic [COST_W:0]   sum_wide;
  logic [COST_W-1:0] sum_sat;
  logic [COST_W-1:0] adv_sat;
  logic              poison;

  // output register
  logic              out_valid_r;
  logic              out_load;
  logic [LBL_W-1:0]  out_dest_r;
  logic [LBL_W-1:0]  out_next_hop_r;
  logic              out_hop_valid_r;
  logic [COST_W-1:0] out_cost_r;
  logic [TTL_W-1:0]  out_ttl_r;
  logic              out_last_r;

  assign idx_last = (idx_r == IDX_W'(TBL - 1));
  assign idx_inc  = idx_r + IDX_W'(1);

  // load: self, neighbor or unreachable
  always_comb begin
    load_entry.ttl = cfg.ttl_default;
    if (cmd.dest == '0) begin
      load_entry.cost = '0;
    end else if (cmd.is_neighbor) begin
      load_entry.cost = COST_W'(1);
    end else begin
      load_entry.cost = cfg.infinity_cost;
    end
    // an entry at infinity carries no next hop
    if (load_entry.cost == cfg.infinity_cost) begin
      load_entry.next_hop  = '0;
      load_entry.hop_valid = 1'b0;
    end else begin
      load_entry.next_hop  = cmd.dest;
      load_entry.hop_valid = 1'b1;
    end
  end

  // receive: refresh, relax through peer or poison on failed node
  always_comb begin
    recv_ttl = (cur_r.adv_cost == '0) ? cfg.ttl_default : rd_a_r.ttl;
    sum_wide = {1'b0, rd_b_r.cost} + {1'b0, cur_r.adv_cost};
    sum_sat  = (sum_wide > {1'b0, cfg.infinity_cost}) ? cfg.infinity_cost
                                                       : sum_wide[COST_W-1:0];
    adv_sat  = (cur_r.adv_cost > cfg.infinity_cost) ? cfg.infinity_cost
                                                     : cur_r.adv_cost;
    rx_entry     = rd_a_r;
    rx_entry.ttl = recv_ttl;
    if (rd_a_r.cost > COST_W'(1)) begin
      if ((rd_a_r.cost > sum_sat) && (recv_ttl != '0)) begin
        rx_entry.cost      = sum_sat;
        rx_entry.next_hop  = cur_r.peer;
        rx_entry.hop_valid = 1'b1;
      end else if (cur_r.adv_ttl == '0) begin
        rx_entry.ttl  = '0;
        rx_entry.cost = adv_sat;
      end
    end
  end

  // age: neighbor TTL drops by one step, floor at zero
  always_comb begin
    age_entry = rd_a_r;
    if (rd_a_r.cost == COST_W'(1)) begin
      age_entry.ttl = (rd_a_r.ttl > cfg.age_step) ? rd_a_r.ttl - cfg.age_step : '0;
    end
  end

  // advertise: expire stale entry, split-horizon poisoning
  always_comb begin
    exp_entry = rd_a_r;
    if (rd_a_r.ttl == '0) begin
      exp_entry.cost = cfg.infinity_cost;
    end
    poison = cfg.split_horizon_on && exp_entry.hop_valid &&
             (exp_entry.next_hop == cur_r.peer) &&
             (exp_entry.next_hop != LBL_W'(idx_r));
  end

  // sequencer next state and memory controls
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    cmd_ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr_a = idx_r;
    rd_addr_b = idx_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_a_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cur_nxt = cmd;
          unique case (cmd.func)
            OP_LOAD: begin
              wr_en   = 1'b1;
              wr_addr = cmd.dest[IDX_W-1:0];
              wr_data = load_entry;
            end
            OP_RECV: begin
              rd_en     = 1'b1;
              rd_addr_a = cmd.dest[IDX_W-1:0];
              rd_addr_b = cmd.peer[IDX_W-1:0];
              state_nxt = ST_RECV;
            end
            OP_AGE: begin
              rd_en     = 1'b1;
              rd_addr_a = '0;
              idx_nxt   = '0;
              state_nxt = ST_AGE;
            end
            OP_ADV: begin
              rd_en     = 1'b1;
              rd_addr_a = '0;
              idx_nxt   = '0;
              state_nxt = ST_ADV;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RECV: begin
        wr_en     = 1'b1;
        wr_addr   = cur_r.dest[IDX_W-1:0];
        wr_data   = rx_entry;
        state_nxt = ST_IDLE;
      end
      ST_AGE: begin
        wr_en   = 1'b1;
        wr_data = age_entry;
        if (idx_last) begin
          state_nxt = ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr_a = idx_inc;
          idx_nxt   = idx_inc;
        end
      end
      ST_ADV: begin
        // hold the entry until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          wr_en    = 1'b1;
          wr_data  = exp_entry;
          if (idx_last) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr_a = idx_inc;
            idx_nxt   = idx_inc;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // current command payload
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dest_r      <= LBL_W'(idx_r);
      out_next_hop_r  <= exp_entry.hop_valid ? exp_entry.next_hop : '0;
      out_hop_valid_r <= exp_entry.hop_valid;
      out_cost_r      <= poison ? cfg.infinity_cost : exp_entry.cost;
      out_ttl_r       <= poison ? cfg.ttl_default : exp_entry.ttl;
      out_last_r      <= idx_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dest      = out_dest_r;
  assign out_next_hop  = out_next_hop_r;
  assign out_hop_valid = out_hop_valid_r;
  assign out_cost      = out_cost_r;
  assign out_ttl       = out_ttl_r;
  assign out_last      = out_last_r;

endmodule

FILE: rtl/core/distance_vector_route_table.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table: distance-vector route table with relaxation
// A 16-entry table of cost, next hop and TTL per destination label, updated
// by load, receive and age items and streamed out by advertise items.
// ----------------------------------------------------------------------------
// Items enter through a two-entry command queue, so up to two items can wait
// while the table sequencer works, and leave as advertisement beats through one
// output register. The table is a single-write-port memory: a load is one write,
// a receive reads the destination and peer entries, then writes back, and
// age and advertise items walk the table one entry per cycle, the advertise
// walk holding while out_ready is low and the output register is full.
// Receive and load items naming a label outside the table are dropped at the
// input. Every entry has to be loaded before a receive, age or advertise
// item reads it; configuration writes take effect at once and belong to
// idle periods.
// ----------------------------------------------------------------------------
module distance_vector_route_table
  import dvrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [LBL_W-1:0]      in_peer,
  input  logic [LBL_W-1:0]      in_dest,
  input  logic [COST_W-1:0]     in_adv_cost,
  input  logic [TTL_W-1:0]      in_adv_ttl,
  input  logic                  in_is_neighbor,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LBL_W-1:0]      out_dest,
  output logic [LBL_W-1:0]      out_next_hop,
  output logic                  out_hop_valid,
  output logic [COST_W-1:0]     out_cost,
  output logic [TTL_W-1:0]      out_ttl,
  output logic                  out_last
);

  logic [COST_W-1:0]       infinity_cost_r;
  logic [TTL_W-1:0]        ttl_default_r;
  logic                    split_horizon_on_r;
  logic [TTL_W-1:0]        age_step_r;
  logic [TTL_W+DIV3_SHIFT-1:0] step_prod;
  cfg_t                    cfg;
  logic                    cmd_valid;
  logic                    cmd_ready;
  cmd_t                    cmd;

  // age step is ttl_default / 3 via reciprocal multiply
  assign step_prod = (TTL_W + DIV3_SHIFT)'(cfg_wdata[TTL_W-1:0]) *
                     (TTL_W + DIV3_SHIFT)'(DIV3_RECIP);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infinity_cost_r    <= COST_W'(16);
      ttl_default_r      <= TTL_W'(90);
      split_horizon_on_r <= 1'b0;
      age_step_r         <= TTL_W'(30);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INF: infinity_cost_r <= cfg_wdata[COST_W-1:0];
        CFG_TTL: begin
          ttl_default_r <= cfg_wdata[TTL_W-1:0];
          age_step_r    <= step_prod[TTL_W+DIV3_SHIFT-1:DIV3_SHIFT];
        end
        CFG_SPLIT: split_horizon_on_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.infinity_cost    = infinity_cost_r;
    cfg.ttl_default      = ttl_default_r;
    cfg.split_horizon_on = split_horizon_on_r;
    cfg.age_step         = age_step_r;
  end

  // input side and command queue
  dvrt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_peer        (in_peer),
    .in_dest        (in_dest),
    .in_adv_cost    (in_adv_cost),
    .in_adv_ttl     (in_adv_ttl),
    .in_is_neighbor (in_is_neighbor),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd)
  );

  // table and sequencer
  dvrt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_dest      (out_dest),
    .out_next_hop  (out_next_hop),
    .out_hop_valid (out_hop_valid),
    .out_cost      (out_cost),
    .out_ttl       (out_ttl),
    .out_last      (out_last)
  );

endmodule

FILE: verif/distance_vector_route_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distance_vector_route_table_test: self-checking bench for the route table
// Loads the whole table, then drives directed load, receive, age and
// advertise items and long random rounds of them under several register
// settings. A mirror of the table predicts every advertisement beat, and a
// monitor compares each beat field by field, in order, with the prediction.
// ----------------------------------------------------------------------------
module distance_vector_route_table_test;
  import dvrt_pkg::*;

  // worst case of queued table walks after the last beat
  localparam int SETTLE_CYCLES = 3 * (TBL + 1) + 4;
  localparam int PHASE_ITEMS   = 45;

  // one predicted advertisement beat
  typedef struct packed {
    logic [LBL_W-1:0]  dest;
    logic [LBL_W-1:0]  next_hop;
    logic              hop_valid;
    logic [COST_W-1:0] cost;
    logic [TTL_W-1:0]  ttl;
    logic              last;
  } adv_beat_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = CFG_INF;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_func        = OP_AGE;
  logic [LBL_W-1:0]      in_peer        = '0;
  logic [LBL_W-1:0]      in_dest        = '0;
  logic [COST_W-1:0]     in_adv_cost    = '0;
  logic [TTL_W-1:0]      in_adv_ttl     = '0;
  logic                  in_is_neighbor = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [LBL_W-1:0]      out_dest;
  logic [LBL_W-1:0]      out_next_hop;
  logic                  out_hop_valid;
  logic [COST_W-1:0]     out_cost;
  logic [TTL_W-1:0]      out_ttl;
  logic                  out_last;

  // mirror of the route table and of the registers
  logic [COST_W-1:0] tbl_cost   [TBL];
  logic [LBL_W-1:0]  tbl_hop    [TBL];
  logic              tbl_hop_ok [TBL];
  logic [TTL_W-1:0]  tbl_ttl    [TBL];
  logic [COST_W-1:0] inf_cost   = 8'd16;
  logic [TTL_W-1:0]  ttl_dflt   = 16'd90;
  logic              split_on   = 1'b0;

  adv_beat_t adv_beats_q[$];
  int        err_count     = 0;
  int        items_sent    = 0;
  int        beats_checked = 0;
  int        settings_used = 0;
  int        burst_left    = 0;
  logic [7:0] stall_cnt    = '0;

  distance_vector_route_table i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_peer        (in_peer),
    .in_dest        (in_dest),
    .in_adv_cost    (in_adv_cost),
    .in_adv_ttl     (in_adv_ttl),
    .in_is_neighbor (in_is_neighbor),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dest       (out_dest),
    .out_next_hop   (out_next_hop),
    .out_hop_valid  (out_hop_valid),
    .out_cost       (out_cost),
    .out_ttl        (out_ttl),
    .out_last       (out_last)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // cost saturated at the current infinity
  function automatic logic [COST_W-1:0] clip_cost(input logic [8:0] v);
    return (v > {1'b0, inf_cost}) ? inf_cost : v[COST_W-1:0];
  endfunction

  // update the mirror for one accepted item and queue its beats
  task automatic apply_route_item(input cmd_t item);
    logic [COST_W-1:0] c;
    logic [COST_W-1:0] sum;
    logic [TTL_W-1:0]  step;
    logic [LBL_W-1:0]  hop;
    logic              ok;
    logic              poison;
    adv_beat_t         beat;
    case (item.func)
      OP_LOAD: begin
        if (item.dest == 0) c = '0;
        else if (item.is_neighbor) c = 8'd1;
        else c = inf_cost;
        tbl_cost[item.dest] = c;
        tbl_ttl[item.dest]  = ttl_dflt;
        tbl_hop[item.dest]    = (c == inf_cost) ? '0 : item.dest;
        tbl_hop_ok[item.dest] = (c != inf_cost);
      end
      OP_RECV: begin
        if (item.adv_cost == 0) tbl_ttl[item.dest] = ttl_dflt;
        if (tbl_cost[item.dest] > 1) begin
          sum = clip_cost({1'b0, tbl_cost[item.peer]} + {1'b0, item.adv_cost});
          if (tbl_cost[item.dest] > sum && tbl_ttl[item.dest] > 0) begin
            tbl_cost[item.dest]   = sum;
            tbl_hop[item.dest]    = item.peer;
            tbl_hop_ok[item.dest] = 1'b1;
          end else if (item.adv_ttl == 0) begin
            tbl_ttl[item.dest]  = '0;
            tbl_cost[item.dest] = clip_cost({1'b0, item.adv_cost});
          end
        end
      end
      OP_AGE: begin
        step = TTL_W'(ttl_dflt / 3);
        for (int j = 0; j < TBL; j++) begin
          if (tbl_cost[j] == 1) tbl_ttl[j] = (tbl_ttl[j] > step) ? tbl_ttl[j] - step : '0;
        end
      end
      default: begin
        // expire dead entries, then stream the table in label order
        for (int j = 0; j < TBL; j++) begin
          if (tbl_ttl[j] == 0) tbl_cost[j] = inf_cost;
        end
        for (int j = 0; j < TBL; j++) begin
          ok     = tbl_hop_ok[j];
          hop    = ok ? tbl_hop[j] : '0;
          poison = split_on && ok && hop == item.peer && hop != LBL_W'(j);
          beat.dest      = LBL_W'(j);
          beat.next_hop  = hop;
          beat.hop_valid = ok;
          beat.cost      = poison ? inf_cost : tbl_cost[j];
          beat.ttl       = poison ? ttl_dflt : tbl_ttl[j];
          beat.last      = (j == TBL - 1);
          adv_beats_q.push_back(beat);
        end
      end
    endcase
  endtask

  // drive one item, in bursts with random gaps
  task automatic send_item(input cmd_t item);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_func        <= item.func;
    in_peer        <= item.peer;
    in_dest        <= item.dest;
    in_adv_cost    <= item.adv_cost;
    in_adv_ttl     <= item.adv_ttl;
    in_is_neighbor <= item.is_neighbor;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_route_item(item);
    items_sent++;
  endtask

  // hold the input until every predicted beat has come out
  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (adv_beats_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers while idle
  task automatic set_config(input logic [COST_W-1:0] inf, input logic [TTL_W-1:0] ttl,
                            input logic split);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INF;
    cfg_wdata <= CFG_DATA_W'(inf);
    @(posedge clk);
    cfg_index <= CFG_TTL;
    cfg_wdata <= ttl;
    @(posedge clk);
    cfg_index <= CFG_SPLIT;
    cfg_wdata <= CFG_DATA_W'(split);
    @(posedge clk);
    cfg_we   <= 1'b0;
    inf_cost = inf;
    ttl_dflt = ttl;
    split_on = split;
    settings_used++;
  endtask

  function automatic cmd_t make_item(input op_t func, input int peer, input int dest,
                                     input int cost, input int ttl, input bit nb);
    cmd_t c;
    c.func        = func;
    c.peer        = LBL_W'(peer);
    c.dest        = LBL_W'(dest);
    c.adv_cost    = COST_W'(cost);
    c.adv_ttl     = TTL_W'(ttl);
    c.is_neighbor = nb;
    return c;
  endfunction

  // receive, mostly from a direct neighbour
  function automatic cmd_t rand_recv();
    int p;
    int cost;
    int ttl;
    p = $urandom_range(0, TBL - 1);
    if ($urandom_range(0, 9) < 7) begin
      for (int k = 0; k < TBL; k++) begin
        if (tbl_cost[(p + k) % TBL] == 1) begin
          p = (p + k) % TBL;
          break;
        end
      end
    end
    case ($urandom_range(0, 3))
      0:       cost = 0;
      3:       cost = $urandom_range(0, 255);
      default: cost = $urandom_range(1, inf_cost);
    endcase
    case ($urandom_range(0, 4))
      0:       ttl = 0;
      1:       ttl = 16'hFFFF;
      default: ttl = $urandom_range(0, 65535);
    endcase
    return make_item(OP_RECV, p, $urandom_range(0, TBL - 1), cost, ttl,
                     $urandom_range(0, 1) == 1);
  endfunction

  // advertise, often to a peer that is somebody's next hop
  function automatic cmd_t rand_adv();
    int p;
    p = ($urandom_range(0, 1) == 1) ? tbl_hop[$urandom_range(0, TBL - 1)]
                                     : $urandom_range(0, TBL - 1);
    return make_item(OP_ADV, p, $urandom_range(0, 15), $urandom_range(0, 255),
                     $urandom_range(0, 65535), $urandom_range(0, 1) == 1);
  endfunction

  function automatic cmd_t rand_any(input op_t func);
    return make_item(func, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 255), $urandom_range(0, 65535),
                     $urandom_range(0, 1) == 1);
  endfunction

  // receiver stall pattern: always ready, sparse stalls, fixed duty, coin flip
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 8'd1;
    case (stall_cnt[7:6])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= (stall_cnt[2:0] < 3'd5);
      default: out_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // compare every output beat with the oldest prediction
  always @(posedge clk) begin
    adv_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (adv_beats_q.size() == 0) begin
        $error("out beat with nothing predicted: dest %0d", out_dest);
        err_count++;
      end else begin
        want = adv_beats_q.pop_front();
        check_field("out_dest", want.dest, out_dest);
        check_field("out_next_hop", want.next_hop, out_next_hop);
        check_field("out_hop_valid", want.hop_valid, out_hop_valid);
        check_field("out_cost", want.cost, out_cost);
        check_field("out_ttl", want.ttl, out_ttl);
        check_field("out_last", want.last, out_last);
        beats_checked++;
      end
    end
  end

  // every label loaded: neighbours 1..5, the rest unreachable, label 0 self
  task automatic test_load_table();
    for (int d = 0; d < TBL; d++) begin
      send_item(make_item(OP_LOAD, $urandom_range(0, 15), d, $urandom_range(0, 255),
                          $urandom_range(0, 65535), d <= 5));
    end
    send_item(make_item(OP_ADV, 0, 0, 0, 0, 0));
  endtask

  // refresh, relaxation, saturation, poisoning, self and peer-equals-dest
  task automatic test_receive_paths();
    send_item(make_item(OP_RECV, 1, 1, 0, 90, 0));
    send_item(make_item(OP_RECV, 2, 9, 3, 50, 1));
    send_item(make_item(OP_RECV, 3, 10, 255, 50, 0));
    send_item(make_item(OP_RECV, 4, 9, 200, 0, 0));
    send_item(make_item(OP_RECV, 5, 0, 7, 0, 1));
    send_item(make_item(OP_RECV, 11, 11, 0, 65535, 1));
    send_item(make_item(OP_ADV, 2, 0, 0, 0, 0));
  endtask

  // neighbour ttl runs down to zero and saturates, then expires on advertise
  task automatic test_age_expiry();
    repeat (4) send_item(make_item(OP_AGE, 0, 0, 0, 0, 0));
    send_item(make_item(OP_ADV, 15, 15, 255, 65535, 1));
  endtask

  // routes learned via the target peer go out poisoned
  task automatic test_split_horizon();
    set_config(8'd16, 16'd90, 1'b1);
    for (int d = 1; d <= 3; d++) send_item(make_item(OP_LOAD, 0, d, 0, 0, 1));
    send_item(make_item(OP_RECV, 2, 12, 1, 9, 0));
    send_item(make_item(OP_ADV, 2, 0, 0, 0, 0));
    send_item(make_item(OP_ADV, 0, 0, 0, 0, 0));
  endtask

  // rounds of loads, receives, optional age and an advertise, plus noise
  task automatic test_random_traffic();
    logic [COST_W-1:0] inf_set   [6];
    logic [TTL_W-1:0]  ttl_set   [6];
    logic              split_set [6];
    int                start;
    inf_set   = '{8'd16, 8'd2, 8'd255, 8'd0, 8'd255, 8'd2};
    ttl_set   = '{16'd90, 16'd3, 16'hFFFF, 16'd0, 16'd3, 16'hFFFF};
    split_set = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    inf_set[3]   = COST_W'($urandom_range(2, 255));
    ttl_set[3]   = TTL_W'($urandom_range(3, 65535));
    split_set[3] = ($urandom_range(0, 1) == 1);
    for (int s = 0; s < 6; s++) begin
      set_config(inf_set[s], ttl_set[s], split_set[s]);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(rand_any(op_t'($urandom_range(0, 3))));
        end else begin
          repeat ($urandom_range(0, 2)) begin
            send_item(make_item(OP_LOAD, $urandom_range(0, 15), $urandom_range(0, TBL - 1),
                                $urandom_range(0, 255), $urandom_range(0, 65535),
                                $urandom_range(0, 2) != 0));
          end
          repeat ($urandom_range(2, 6)) send_item(rand_recv());
          if ($urandom_range(0, 9) < 3) send_item(rand_any(OP_AGE));
          send_item(rand_adv());
        end
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_table();
    test_receive_paths();
    test_age_expiry();
    test_split_horizon();
    test_random_traffic();
    drain_results();
    $display("summary: %0d items sent, %0d advertisement beats compared,", items_sent,
             beats_checked);
    $display("summary: %0d register settings including the extremes", settings_used);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
